// File: design/htfl_pkg.sv
package htfl_pkg;

  // Width of the free-list link kept in a freed entry.
  localparam int unsigned LINK_W = 17;

  // Payload field widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned HANDLE_W = 10;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 2;

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_GET = 2'd1,
    OP_DEL = 2'd2
  } htfl_op_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } htfl_status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } htfl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // a request word is taken this cycle
    logic finish;    // second phase of a request that read the table
    logic load_out;  // load the response register
  } htfl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;  // the offered request needs a table read
  } htfl_stat_t;

endpackage

// File: design/htfl_req_if.sv
interface htfl_req_if
  import htfl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [HANDLE_W-1:0] handle_in;
  logic [VALUE_W-1:0]  value_in;

  modport source (output valid, opcode, handle_in, value_in, input ready);
  modport sink   (input valid, opcode, handle_in, value_in, output ready);
endinterface

// File: design/htfl_rsp_if.sv
interface htfl_rsp_if
  import htfl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] handle_out;
  logic [VALUE_W-1:0]  value_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, handle_out, value_out, status, input ready);
  modport sink   (input valid, handle_out, value_out, status, output ready);
endinterface

// File: design/htfl_ram.sv
module htfl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/htfl_ctrl.sv
module htfl_ctrl
  import htfl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  input  htfl_stat_t stat_i,
  output htfl_cmd_t  cmd_o
);

  htfl_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        out_free;

  // State and response-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // The response register is free when empty or drained this cycle.
  assign out_free = !rsp_valid_q || rsp_ready_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        req_ready_o    = out_free;
        cmd_o.accept   = req_valid_i && out_free;
        cmd_o.load_out = cmd_o.accept && !stat_i.need_read;
        if (cmd_o.accept && stat_i.need_read) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.finish   = 1'b1;
        cmd_o.load_out = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Response valid is set on a load and cleared when the word is taken.
  always_comb begin
    if (cmd_o.load_out) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: design/htfl_dp.sv
module htfl_dp
  import htfl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htfl_cmd_t           cmd_i,
  output htfl_stat_t          stat_o,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [HANDLE_W-1:0] handle_in_i,
  input  logic [VALUE_W-1:0]  value_in_i,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [VALUE_W-1:0]  value_out_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned UsedW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MemW  = (VALUE_WIDTH > LINK_W) ? VALUE_WIDTH : LINK_W;
  localparam logic [LINK_W-1:0] DepthL = LINK_W'(TABLE_DEPTH);

  // Free-list head and fill count.
  logic [LINK_W-1:0]      head_q, head_d;
  logic [UsedW-1:0]       used_q, used_d;
  // Request held across the read phase.
  logic [OP_W-1:0]        op_q;
  logic [AddrW-1:0]       addr_q;
  logic [VALUE_WIDTH-1:0] value_q;
  // Response register.
  logic [HANDLE_W-1:0]    handle_out_q, handle_out_d;
  logic [VALUE_W-1:0]     value_out_q, value_out_d;
  logic [STATUS_W-1:0]    status_q, status_d;

  logic [LINK_W-1:0]      used_ext, h_ext;
  logic [VALUE_WIDTH-1:0] v_in;
  logic                   is_add, is_get, is_del;
  logic                   do_append, do_reuse, h_valid;
  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_addr;
  logic [MemW-1:0]        ram_wdata, ram_rdata;

  assign used_ext = LINK_W'(used_q);
  assign h_ext    = LINK_W'(handle_in_i);
  assign v_in     = value_in_i[VALUE_WIDTH-1:0];

  // Decode of the offered request.
  assign is_add    = (opcode_i == OP_ADD);
  assign is_get    = (opcode_i == OP_GET);
  assign is_del    = (opcode_i == OP_DEL);
  assign do_append = is_add && (head_q == used_ext) && (used_ext < DepthL);
  assign do_reuse  = is_add && (head_q != '0) && (head_q < used_ext) && (head_q < DepthL);
  assign h_valid   = (h_ext != '0) && (h_ext < used_ext) && (h_ext < DepthL);

  assign stat_o.need_read = do_reuse || (is_get && h_valid);

  // Table port: first phase writes or reads, the read phase of an add
  // writes the new value over the link it just read.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    if (cmd_i.finish) begin
      ram_we    = (op_q == OP_ADD);
      ram_addr  = addr_q;
      ram_wdata = MemW'(value_q);
    end else if (cmd_i.accept) begin
      if (do_append) begin
        ram_we    = 1'b1;
        ram_addr  = AddrW'(head_q);
        ram_wdata = MemW'(v_in);
      end else if (is_del && h_valid) begin
        ram_we    = 1'b1;
        ram_addr  = AddrW'(h_ext);
        ram_wdata = MemW'(head_q);
      end else if (do_reuse) begin
        ram_re   = 1'b1;
        ram_addr = AddrW'(head_q);
      end else if (is_get && h_valid) begin
        ram_re   = 1'b1;
        ram_addr = AddrW'(h_ext);
      end
    end
  end

  htfl_ram #(
    .WIDTH (MemW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Head and count updates.
  always_comb begin
    head_d = head_q;
    used_d = used_q;
    if (cmd_i.finish) begin
      if (op_q == OP_ADD) begin
        head_d = ram_rdata[LINK_W-1:0];
      end
    end else if (cmd_i.accept) begin
      if (do_append) begin
        used_d = used_q + 1'b1;
        head_d = LINK_W'(used_q + 1'b1);
      end else if (is_del && h_valid) begin
        head_d = h_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= LINK_W'(1);
      used_q <= UsedW'(1);
    end else begin
      head_q <= head_d;
      used_q <= used_d;
    end
  end

  // Request capture for the read phase.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= opcode_i;
      addr_q  <= ram_addr;
      value_q <= v_in;
    end
  end

  // Response word for either phase.
  always_comb begin
    handle_out_d = '0;
    value_out_d  = '0;
    status_d     = STAT_OK;
    if (cmd_i.finish) begin
      if (op_q == OP_ADD) begin
        handle_out_d = HANDLE_W'(addr_q);
      end else begin
        value_out_d = VALUE_W'(ram_rdata[VALUE_WIDTH-1:0]);
      end
    end else if (is_add) begin
      if (do_append) begin
        handle_out_d = HANDLE_W'(head_q);
      end else begin
        status_d = STAT_FULL;
      end
    end else if (!(is_get || is_del) || !h_valid) begin
      status_d = STAT_INVALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      handle_out_q <= handle_out_d;
      value_out_q  <= value_out_d;
      status_q     <= status_d;
    end
  end

  assign handle_out_o = handle_out_q;
  assign value_out_o  = value_out_q;
  assign status_o     = status_q;

endmodule

// File: design/handle_table_free_list_core.sv
// Channel   Dir  Fields                              Word
// req_i     in   opcode, handle_in, value_in         one request
// rsp_o     out  handle_out, value_out, status       one response per request
//
// An add that appends, a delete and any rejected request load their response in
// the cycle of acceptance. An add that reuses a freed slot and a valid get load
// it in the read cycle that follows: the single table port registers its read.
// Reset sets the free-list head and used count to 1; the table itself is not
// cleared, since only written slots are ever read.
// A new request is taken when the response register is empty or drained in the
// same cycle, and never during the read cycle.
module handle_table_free_list_core
  import htfl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htfl_req_if.sink   req_i,
  htfl_rsp_if.source rsp_o
);

  htfl_cmd_t  cmd;
  htfl_stat_t stat;

  // Sequencer.
  htfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Table, free list and response register.
  htfl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .opcode_i     (req_i.opcode),
    .handle_in_i  (req_i.handle_in),
    .value_in_i   (req_i.value_in),
    .handle_out_o (rsp_o.handle_out),
    .value_out_o  (rsp_o.value_out),
    .status_o     (rsp_o.status)
  );

`ifndef ASSERT_OFF
  // A held response word is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response register loaded while a word is held");

  // A request that reads the table is finished in the next cycle.
  a_read_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && stat.need_read) |=> (cmd.finish && !req_i.ready))
    else $error("table read not followed by its finishing cycle");

  // A loaded response word is shown as valid in the next cycle.
  a_rsp_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> rsp_o.valid)
    else $error("loaded response not shown as valid");

  // A full-table answer carries handle zero.
  a_full_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == STAT_FULL)) |-> (rsp_o.handle_out == '0))
    else $error("full status with a nonzero handle");
`endif

endmodule
